@@ src/bole_pkg.sv @@
// Shared types and codes for the bounded ordered list engine.
// Used by the channel interfaces, the controller and the top level.
package bole_pkg;

  localparam int COMMAND_W  = 3;
  localparam int VALUE_W    = 32;
  localparam int POSITION_W = 8;
  localparam int COUNT_W    = 9;
  localparam int STATUS_W   = 2;

  typedef enum logic [COMMAND_W-1:0] {
    CMD_ADD_BACK   = 3'd0,
    CMD_POP_BACK   = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_ERASE      = 3'd5,
    CMD_SIZE       = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_INS,
    S_INS_LAST,
    S_ERA_HEAD,
    S_ERA,
    S_RESP
  } state_t;

  typedef struct packed {
    cmd_code_t                    command;
    logic signed [VALUE_W-1:0]    value;
    logic        [POSITION_W-1:0] position;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] removed_value;
    logic        [COUNT_W-1:0] entry_count;
    status_t                   status;
  } result_t;

endpackage

@@ src/bole_cmd_if.sv @@
// Command request channel of the list engine: valid/ready plus payload.
// Depends on bole_pkg for the field widths.
interface bole_cmd_if;
  logic                                  valid;
  logic                                  ready;
  logic        [bole_pkg::COMMAND_W-1:0]  command;
  logic signed [bole_pkg::VALUE_W-1:0]    value;
  logic        [bole_pkg::POSITION_W-1:0] position;

  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

@@ src/bole_res_if.sv @@
// Result request channel of the list engine: valid/ready plus payload.
// Depends on bole_pkg for the field widths.
interface bole_res_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bole_pkg::VALUE_W-1:0]  removed_value;
  logic        [bole_pkg::COUNT_W-1:0]  entry_count;
  logic        [bole_pkg::STATUS_W-1:0] status;

  modport source (output valid, removed_value, entry_count, status, input ready);
  modport sink   (input valid, removed_value, entry_count, status, output ready);
endinterface

@@ src/bole_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/bole_ctrl.sv @@
// Command sequencer of the list engine: head and count registers, ring
// addressing and the read-modify-write walk over the value store.
// Depends on bole_pkg; drives an external bole_ram.
module bole_ctrl #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  bole_pkg::cmd_t                cmd,
  input  logic                          res_free,
  output logic                          res_load,
  output bole_pkg::result_t             res,
  output logic                          mem_we,
  output logic [$clog2(CAPACITY)-1:0]   mem_waddr,
  output logic [DATA_WIDTH-1:0]         mem_wdata,
  output logic                          mem_re,
  output logic [$clog2(CAPACITY)-1:0]   mem_raddr,
  input  logic [DATA_WIDTH-1:0]         mem_rdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > bole_pkg::COUNT_W) ? CW : bole_pkg::COUNT_W;

  bole_pkg::state_t    state, state_next;
  bole_pkg::cmd_code_t op, op_next;
  bole_pkg::status_t   status, status_next;
  logic [DATA_WIDTH-1:0]                val_reg, val_next;
  logic [bole_pkg::POSITION_W-1:0]      pos_reg, pos_next;
  logic [AW-1:0]                        head, head_next;
  logic [CW-1:0]                        count, count_next;
  logic [CW-1:0]                        idx, idx_next;
  logic signed [bole_pkg::VALUE_W-1:0]  removed, removed_next;

  logic signed [63:0]                   val_wide;
  logic signed [63:0]                   rd_wide;
  logic [XW-1:0] pos_x, pos1_x, count_x, idx_x;
  logic          full, empty, accept;
  logic          pop_go, ins_shift, era_go;
  logic [AW-1:0] head_inc, head_dec;
  logic [CW-1:0] idx_p1, idx_p2;

  // Ring address of element i counted from the head; i stays below CAPACITY.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(i);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return AW'(s);
  endfunction

  assign cmd_ready = (state == bole_pkg::S_IDLE);
  assign accept    = cmd_valid && cmd_ready;

  assign val_wide = 64'(cmd.value);
  assign rd_wide  = 64'(signed'(mem_rdata));

  assign pos_x   = XW'(pos_reg);
  assign pos1_x  = pos_x + XW'(1);
  assign count_x = XW'(count);
  assign idx_x   = XW'(idx);
  assign full    = (count == CW'(CAPACITY));
  assign empty   = (count == '0);
  assign idx_p1  = idx + CW'(1);
  assign idx_p2  = CW'({1'b0, idx} + (CW+1)'(2));

  assign head_inc = (head == AW'(CAPACITY - 1)) ? '0 : head + AW'(1);
  assign head_dec = (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);

  assign pop_go    = ((op == bole_pkg::CMD_POP_BACK) || (op == bole_pkg::CMD_POP_FRONT))
                     && !empty;
  assign ins_shift = (op == bole_pkg::CMD_INSERT) && (pos_x < count_x) && !full
                     && (count_x > pos1_x);
  assign era_go    = (op == bole_pkg::CMD_ERASE) && (pos1_x < count_x);

  always_comb begin
    state_next = state;
    unique case (state)
      bole_pkg::S_IDLE: begin
        if (accept) state_next = bole_pkg::S_EXEC;
      end
      bole_pkg::S_EXEC: begin
        if (pop_go)         state_next = bole_pkg::S_POP;
        else if (ins_shift) state_next = bole_pkg::S_INS;
        else if (era_go)    state_next = bole_pkg::S_ERA_HEAD;
        else                state_next = bole_pkg::S_RESP;
      end
      bole_pkg::S_POP:      state_next = bole_pkg::S_RESP;
      bole_pkg::S_INS: begin
        if (idx_x <= pos1_x) state_next = bole_pkg::S_INS_LAST;
      end
      bole_pkg::S_INS_LAST: state_next = bole_pkg::S_RESP;
      bole_pkg::S_ERA_HEAD: begin
        if (XW'(idx_p1) < count_x) state_next = bole_pkg::S_ERA;
        else                       state_next = bole_pkg::S_RESP;
      end
      bole_pkg::S_ERA: begin
        if (XW'(idx_p2) >= count_x) state_next = bole_pkg::S_RESP;
      end
      bole_pkg::S_RESP: begin
        if (res_free) state_next = bole_pkg::S_IDLE;
      end
      default: state_next = bole_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_next      = op;
    status_next  = status;
    val_next     = val_reg;
    pos_next     = pos_reg;
    head_next    = head;
    count_next   = count;
    idx_next     = idx;
    removed_next = removed;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = val_reg;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    res_load     = 1'b0;
    unique case (state)
      bole_pkg::S_IDLE: begin
        if (accept) begin
          op_next      = cmd.command;
          val_next     = val_wide[DATA_WIDTH-1:0];
          pos_next     = cmd.position;
          removed_next = '0;
          status_next  = bole_pkg::ST_OK;
        end
      end
      bole_pkg::S_EXEC: begin
        unique case (op)
          bole_pkg::CMD_ADD_BACK: begin
            if (full) begin
              status_next = bole_pkg::ST_FULL;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = slot(head, count);
              count_next = count + CW'(1);
            end
          end
          bole_pkg::CMD_POP_BACK: begin
            if (empty) begin
              status_next = bole_pkg::ST_EMPTY;
            end else begin
              mem_re     = 1'b1;
              mem_raddr  = slot(head, count - CW'(1));
              count_next = count - CW'(1);
            end
          end
          bole_pkg::CMD_PUSH_FRONT: begin
            if (full) begin
              status_next = bole_pkg::ST_FULL;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = head_dec;
              head_next  = head_dec;
              count_next = count + CW'(1);
            end
          end
          bole_pkg::CMD_POP_FRONT: begin
            if (empty) begin
              status_next = bole_pkg::ST_EMPTY;
            end else begin
              mem_re     = 1'b1;
              mem_raddr  = head;
              head_next  = head_inc;
              count_next = count - CW'(1);
            end
          end
          bole_pkg::CMD_INSERT: begin
            // The range check takes precedence over the full check.
            if (pos_x >= count_x) begin
              status_next = bole_pkg::ST_RANGE;
            end else if (full) begin
              status_next = bole_pkg::ST_FULL;
            end else if (ins_shift) begin
              mem_re    = 1'b1;
              mem_raddr = slot(head, count - CW'(1));
              idx_next  = count - CW'(1);
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = slot(head, CW'(pos1_x));
              count_next = count + CW'(1);
            end
          end
          bole_pkg::CMD_ERASE: begin
            if (!era_go) begin
              status_next = bole_pkg::ST_RANGE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = slot(head, CW'(pos1_x));
              idx_next  = CW'(pos1_x);
            end
          end
          bole_pkg::CMD_SIZE: begin
          end
          bole_pkg::CMD_CLEAR: begin
            count_next = '0;
            head_next  = '0;
          end
        endcase
      end
      bole_pkg::S_POP: begin
        removed_next = rd_wide[bole_pkg::VALUE_W-1:0];
      end
      bole_pkg::S_INS: begin
        // Move element idx up one slot while fetching the one below it.
        mem_we    = 1'b1;
        mem_waddr = slot(head, idx_p1);
        mem_wdata = mem_rdata;
        if (idx_x > pos1_x) begin
          mem_re    = 1'b1;
          mem_raddr = slot(head, idx - CW'(1));
          idx_next  = idx - CW'(1);
        end
      end
      bole_pkg::S_INS_LAST: begin
        mem_we     = 1'b1;
        mem_waddr  = slot(head, CW'(pos1_x));
        count_next = count + CW'(1);
      end
      bole_pkg::S_ERA_HEAD: begin
        removed_next = rd_wide[bole_pkg::VALUE_W-1:0];
        if (XW'(idx_p1) < count_x) begin
          mem_re    = 1'b1;
          mem_raddr = slot(head, idx_p1);
        end else begin
          count_next = count - CW'(1);
        end
      end
      bole_pkg::S_ERA: begin
        // Read data holds element idx+1; it moves down into slot idx.
        mem_we    = 1'b1;
        mem_waddr = slot(head, idx);
        mem_wdata = mem_rdata;
        idx_next  = idx_p1;
        if (XW'(idx_p2) < count_x) begin
          mem_re    = 1'b1;
          mem_raddr = slot(head, idx_p2);
        end else begin
          count_next = count - CW'(1);
        end
      end
      bole_pkg::S_RESP: begin
        res_load = res_free;
      end
      default: begin
      end
    endcase
  end

  assign res.removed_value = removed;
  assign res.entry_count   = bole_pkg::COUNT_W'(count);
  assign res.status        = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bole_pkg::S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
    op      <= op_next;
    status  <= status_next;
    val_reg <= val_next;
    pos_reg <= pos_next;
    idx     <= idx_next;
    removed <= removed_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("list count above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= AW'(CAPACITY - 1))
    else $error("head pointer outside the ring");

  a_no_same_slot: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("store read and written at the same slot in one cycle");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |->
      ((op == bole_pkg::CMD_CLEAR) || (count == $past(count) + CW'(1))
       || (count + CW'(1) == $past(count))))
    else $error("count moved by more than one entry");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    ((state == bole_pkg::S_RESP) && (status == bole_pkg::ST_FULL)) |->
      (count == CW'(CAPACITY)))
    else $error("full status reported while not full");

endmodule

@@ src/bounded_ordered_list_engine.sv @@
// Bounded ordered list engine: keeps up to CAPACITY signed values in a ring
// store with push and pop at both ends, insert after and erase after a
// position, size and clear; every command request yields one result request.
// One command is in work at a time. Insert and erase move the entries
// behind the target one per cycle through the store's single read port and
// single write port. A new command is accepted as soon as the previous
// one has been loaded into the result register, even while that result waits.
// The store needs no clearing pass after reset. Depends on bole_pkg,
// bole_cmd_if, bole_res_if, bole_ram and bole_ctrl.
module bounded_ordered_list_engine #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input logic         clk,
  input logic         rst,
  bole_cmd_if.sink    cmd,
  bole_res_if.source  res
);

  localparam int AW = $clog2(CAPACITY);

  bole_pkg::cmd_t    cmd_word;
  bole_pkg::result_t res_word;
  bole_pkg::result_t res_hold;
  logic              res_valid;
  logic              res_free;
  logic              res_load;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  assign cmd_word.command  = bole_pkg::cmd_code_t'(cmd.command);
  assign cmd_word.value    = cmd.value;
  assign cmd_word.position = cmd.position;

  bole_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd       (cmd_word),
    .res_free  (res_free),
    .res_load  (res_load),
    .res       (res_word),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  bole_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result register: takes a new result when empty or being drained.
  assign res_free = !res_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
    if (res_load) begin
      res_hold <= res_word;
    end
  end

  assign res.valid         = res_valid;
  assign res.removed_value = res_hold.removed_value;
  assign res.entry_count   = res_hold.entry_count;
  assign res.status        = res_hold.status;

endmodule

@@ bench/testbench.sv @@
// Testbench for bounded_ordered_list_engine: directed and random command traffic
// checked against a behavioral list kept in the bench, with random stalls.
// Depends on bole_pkg, bole_cmd_if, bole_res_if and the engine RTL.
module testbench;

  localparam int CAPACITY    = 256;
  localparam int SW          = $clog2(CAPACITY);
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 20000;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic recv_ready = 1'b0;
  logic hold_active = 1'b0;

  int send_idle_pct = 12;
  int recv_idle_pct = 45;
  int fail_count = 0;
  int cycle_count = 0;

  // Behavioral copy of the list: ring store, head slot and fill level.
  logic signed [bole_pkg::VALUE_W-1:0] shadow_store [CAPACITY];
  int shadow_head = 0;
  int shadow_count = 0;
  bole_pkg::result_t pending_results [$];

  bole_cmd_if cmd_ch ();
  bole_res_if res_ch ();

  assign res_ch.ready = recv_ready;

  bounded_ordered_list_engine u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [SW-1:0] slot_of(input int idx);
    return SW'((shadow_head + idx) % CAPACITY);
  endfunction

  function automatic bole_pkg::result_t apply_list_command(
      input bole_pkg::cmd_code_t c,
      input logic signed [bole_pkg::VALUE_W-1:0] v,
      input logic [bole_pkg::POSITION_W-1:0] p);
    bole_pkg::result_t r;
    int pos;
    pos = int'(p);
    r.removed_value = '0;
    r.status = bole_pkg::ST_OK;
    case (c)
      bole_pkg::CMD_ADD_BACK: begin
        if (shadow_count >= CAPACITY) r.status = bole_pkg::ST_FULL;
        else begin
          shadow_store[slot_of(shadow_count)] = v;
          shadow_count++;
        end
      end
      bole_pkg::CMD_PUSH_FRONT: begin
        if (shadow_count >= CAPACITY) r.status = bole_pkg::ST_FULL;
        else begin
          shadow_head = (shadow_head + CAPACITY - 1) % CAPACITY;
          shadow_store[slot_of(0)] = v;
          shadow_count++;
        end
      end
      bole_pkg::CMD_POP_BACK: begin
        if (shadow_count == 0) r.status = bole_pkg::ST_EMPTY;
        else begin
          shadow_count--;
          r.removed_value = shadow_store[slot_of(shadow_count)];
        end
      end
      bole_pkg::CMD_POP_FRONT: begin
        if (shadow_count == 0) r.status = bole_pkg::ST_EMPTY;
        else begin
          r.removed_value = shadow_store[slot_of(0)];
          shadow_head = (shadow_head + 1) % CAPACITY;
          shadow_count--;
        end
      end
      bole_pkg::CMD_INSERT: begin
        // The position check takes precedence over the full check.
        if (pos >= shadow_count) r.status = bole_pkg::ST_RANGE;
        else if (shadow_count >= CAPACITY) r.status = bole_pkg::ST_FULL;
        else begin
          for (int i = shadow_count; i > pos + 1; i--)
            shadow_store[slot_of(i)] = shadow_store[slot_of(i - 1)];
          shadow_store[slot_of(pos + 1)] = v;
          shadow_count++;
        end
      end
      bole_pkg::CMD_ERASE: begin
        if (pos + 1 >= shadow_count) r.status = bole_pkg::ST_RANGE;
        else begin
          r.removed_value = shadow_store[slot_of(pos + 1)];
          for (int i = pos + 1; i + 1 < shadow_count; i++)
            shadow_store[slot_of(i)] = shadow_store[slot_of(i + 1)];
          shadow_count--;
        end
      end
      bole_pkg::CMD_SIZE: begin
      end
      default: begin
        shadow_count = 0;
        shadow_head = 0;
      end
    endcase
    r.entry_count = bole_pkg::COUNT_W'(shadow_count);
    return r;
  endfunction

  // Leaves valid high after acceptance; the next call or the end of the run
  // decides in the same time step whether it stays up.
  task automatic send_command(input bole_pkg::cmd_code_t c,
                              input logic signed [bole_pkg::VALUE_W-1:0] v,
                              input logic [bole_pkg::POSITION_W-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.command  <= c;
    cmd_ch.value    <= v;
    cmd_ch.position <= p;
    do @(posedge clk); while (!cmd_ch.ready);
    pending_results.insert(pending_results.size(), apply_list_command(c, v, p));
  endtask

  task automatic check_result();
    bole_pkg::result_t want;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: removed %0d count %0d status %0d",
                 res_ch.removed_value, res_ch.entry_count, res_ch.status);
    end else begin
      want = pending_results.pop_front();
      if (res_ch.removed_value !== want.removed_value ||
          res_ch.entry_count !== want.entry_count ||
          res_ch.status !== want.status) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch: expected removed %0d count %0d status %s, got %0d %0d %0d",
                   want.removed_value, want.entry_count, want.status.name(),
                   res_ch.removed_value, res_ch.entry_count, res_ch.status);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      recv_ready <= 1'b0;
    end else begin
      if (res_ch.valid && recv_ready) check_result();
      if (hold_active) recv_ready <= 1'b0;
      else recv_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_empty_list();
    send_command(bole_pkg::CMD_POP_BACK, 32'sd5, 8'd0);
    send_command(bole_pkg::CMD_POP_FRONT, -32'sd5, 8'd0);
    send_command(bole_pkg::CMD_ERASE, 32'sd0, 8'd0);
    send_command(bole_pkg::CMD_ERASE, 32'sd0, 8'd255);
    send_command(bole_pkg::CMD_INSERT, 32'sd17, 8'd0);
    send_command(bole_pkg::CMD_INSERT, 32'sd17, 8'd255);
    send_command(bole_pkg::CMD_SIZE, 32'sd0, 8'd0);
    send_command(bole_pkg::CMD_CLEAR, 32'sd0, 8'd0);
  endtask

  task automatic test_edge_values();
    send_command(bole_pkg::CMD_ADD_BACK, 32'sh7FFFFFFF, 8'd0);
    send_command(bole_pkg::CMD_ADD_BACK, 32'sh80000000, 8'd0);
    send_command(bole_pkg::CMD_PUSH_FRONT, 32'sd0, 8'd0);
    send_command(bole_pkg::CMD_PUSH_FRONT, -32'sd1, 8'd0);
    send_command(bole_pkg::CMD_INSERT, 32'sh55555555, 8'd0);
    // Inserting after the last element appends.
    send_command(bole_pkg::CMD_INSERT, 32'shAAAAAAAA, 8'd4);
    send_command(bole_pkg::CMD_INSERT, 32'sd9, 8'd6);
    send_command(bole_pkg::CMD_ERASE, 32'sd0, 8'd0);
    send_command(bole_pkg::CMD_ERASE, 32'sd0, 8'd3);
    send_command(bole_pkg::CMD_ERASE, 32'sd0, 8'd3);
    send_command(bole_pkg::CMD_SIZE, 32'sd0, 8'd128);
    send_command(bole_pkg::CMD_POP_BACK, 32'sd0, 8'd0);
    send_command(bole_pkg::CMD_POP_FRONT, 32'sd0, 8'd0);
    send_command(bole_pkg::CMD_CLEAR, 32'sd0, 8'd0);
  endtask

  task automatic test_full_list();
    while (shadow_count < CAPACITY)
      send_command($urandom_range(1) ? bole_pkg::CMD_ADD_BACK : bole_pkg::CMD_PUSH_FRONT,
                   $urandom(), bole_pkg::POSITION_W'($urandom_range(255)));
    send_command(bole_pkg::CMD_ADD_BACK, 32'sd1, 8'd0);
    send_command(bole_pkg::CMD_PUSH_FRONT, 32'sd2, 8'd0);
    send_command(bole_pkg::CMD_INSERT, 32'sd3, 8'd255);
    send_command(bole_pkg::CMD_INSERT, 32'sd4, 8'd100);
    send_command(bole_pkg::CMD_ERASE, 32'sd0, 8'd254);
    send_command(bole_pkg::CMD_ERASE, 32'sd0, 8'd254);
    send_command(bole_pkg::CMD_INSERT, 32'sd5, 8'd254);
    send_command(bole_pkg::CMD_ERASE, 32'sd0, 8'd0);
    send_command(bole_pkg::CMD_POP_FRONT, 32'sd0, 8'd0);
    send_command(bole_pkg::CMD_POP_BACK, 32'sd0, 8'd0);
    send_command(bole_pkg::CMD_CLEAR, 32'sd0, 8'd0);
  endtask

  // The result side stops for a long stretch so the engine fills and
  // stalls its command input while requests keep coming.
  task automatic test_backpressure();
    send_idle_pct = 0;
    fork
      begin
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
      end
    join_none
    for (int k = 0; k < 16; k++)
      send_command(bole_pkg::cmd_code_t'(bole_pkg::COMMAND_W'($urandom_range(3))),
                   $urandom(), bole_pkg::POSITION_W'($urandom_range(255)));
  endtask

  task automatic test_random_traffic(input int n_items, input int send_pct,
                                     input int recv_pct);
    int target;
    int roll;
    bit grow;
    bole_pkg::cmd_code_t c;
    logic [bole_pkg::POSITION_W-1:0] p;
    logic signed [bole_pkg::VALUE_W-1:0] v;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = 0;
    for (int k = 0; k < n_items; k++) begin
      // The fill level drifts toward a target that moves now and then.
      if (k % 128 == 0)
        target = ($urandom_range(3) == 0) ? CAPACITY : $urandom_range(CAPACITY);
      grow = (shadow_count < target);
      roll = $urandom_range(999);
      if (roll < 5) c = bole_pkg::CMD_CLEAR;
      else if (roll < 40) c = bole_pkg::CMD_SIZE;
      else begin
        if (roll >= 820) grow = !grow;
        case ($urandom_range(2))
          0: c = grow ? bole_pkg::CMD_ADD_BACK : bole_pkg::CMD_POP_BACK;
          1: c = grow ? bole_pkg::CMD_PUSH_FRONT : bole_pkg::CMD_POP_FRONT;
          default: c = grow ? bole_pkg::CMD_INSERT : bole_pkg::CMD_ERASE;
        endcase
      end
      p = bole_pkg::POSITION_W'($urandom_range(255));
      if ((c == bole_pkg::CMD_INSERT || c == bole_pkg::CMD_ERASE) && $urandom_range(9) != 0)
      begin
        if (c == bole_pkg::CMD_INSERT && shadow_count >= 1)
          p = bole_pkg::POSITION_W'($urandom_range(shadow_count - 1));
        else if (c == bole_pkg::CMD_ERASE && shadow_count >= 2)
          p = bole_pkg::POSITION_W'($urandom_range(shadow_count - 2));
      end
      if ($urandom_range(15) == 0) v = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      else v = $urandom();
      send_command(c, v, p);
    end
  endtask

  initial begin
    int waited;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.command  <= bole_pkg::CMD_SIZE;
    cmd_ch.value    <= '0;
    cmd_ch.position <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_edge_values();
    test_full_list();
    test_backpressure();
    test_random_traffic(280, 12, 45);
    test_random_traffic(280, 45, 12);
    test_random_traffic(280, 0, 0);
    cmd_ch.valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (CAPACITY + 8) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ bounded_ordered_list_engine.f @@
src/bole_pkg.sv
src/bole_cmd_if.sv
src/bole_res_if.sv
src/bole_ram.sv
src/bole_ctrl.sv
src/bounded_ordered_list_engine.sv
bench/testbench.sv
